// ----- design/bpc_pkg.sv -----
package bpc_pkg;

	// number of button lanes; pins exist for the first four
	localparam int unsigned BUTTONS = 4;
	localparam int unsigned PIN_W = 4;
	localparam int unsigned AGE_W = 16;
	localparam logic [AGE_W-1:0] AGE_MAX = '1;
	// packed result fields before byte padding
	localparam int unsigned RES_W = 12;

	// reset values of the timing registers
	localparam logic [AGE_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [AGE_W-1:0] LONG_PRESS_RST = 16'd1000;

	typedef enum logic [2:0] {
		PH_RELEASED,
		PH_PRESS_DB,
		PH_PRESSED,
		PH_LONG,
		PH_RELEASE_DB
	} bpc_phase_t;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_SHORT = 2'd1,
		REQ_LONG = 2'd2
	} bpc_req_t;

	typedef enum logic [1:0] {
		CFG_DEBOUNCE = 2'd0,
		CFG_LONG_PRESS = 2'd1
	} bpc_cfg_t;

	// what one lane reports to the merge logic
	typedef struct packed {
		logic pressed;      // lane sits in the pressed phase now
		logic short_flag;   // short flag before this beat
		logic long_flag;    // long flag before this beat
		logic short_next;   // short flag after this beat
		logic long_next;    // long flag after this beat
	} bpc_lane_status_t;

endpackage

// ----- design/bpc_lane.sv -----
module bpc_lane
	import bpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick,
	input  logic                 down,
	input  logic                 clr_short,
	input  logic                 clr_long,
	input  logic [AGE_W-1:0]     debounce_ticks,
	input  logic [AGE_W-1:0]     long_press_ticks,
	output bpc_lane_status_t     status
);

	bpc_phase_t phase_q, phase_d;
	logic [AGE_W-1:0] age_q, age_d, age_inc;
	logic from_long_q, from_long_d;
	logic short_q, long_q;
	logic set_short, set_long;
	logic short_d, long_d;

	assign age_inc = (age_q == AGE_MAX) ? age_q : age_q + AGE_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RELEASED;
			age_q <= '0;
			from_long_q <= 1'b0;
			short_q <= 1'b0;
			long_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			age_q <= age_d;
			from_long_q <= from_long_d;
			short_q <= short_d;
			long_q <= long_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		age_d = age_q;
		from_long_d = from_long_q;
		set_short = 1'b0;
		set_long = 1'b0;
		if (tick) begin
			age_d = age_inc;
			case (phase_q)
				PH_PRESS_DB: begin
					if (age_inc >= debounce_ticks) begin
						if (down) begin
							phase_d = PH_PRESSED;
							age_d = '0;
						end else begin
							phase_d = PH_RELEASED;
						end
					end
				end
				PH_PRESSED: begin
					if (!down) begin
						from_long_d = 1'b0;
						phase_d = PH_RELEASE_DB;
						age_d = '0;
					end else if (age_inc >= long_press_ticks) begin
						phase_d = PH_LONG;
						set_long = 1'b1;
					end
				end
				PH_LONG: begin
					if (!down) begin
						from_long_d = 1'b1;
						phase_d = PH_RELEASE_DB;
						age_d = '0;
					end
				end
				PH_RELEASE_DB: begin
					if (age_inc >= debounce_ticks) begin
						if (!down) begin
							set_short = !from_long_q;
							phase_d = PH_RELEASED;
						end else begin
							// bounce back keeps the age running
							phase_d = PH_PRESSED;
						end
					end
				end
				default: begin
					if (down) begin
						phase_d = PH_PRESS_DB;
						age_d = '0;
					end else begin
						phase_d = PH_RELEASED;
					end
				end
			endcase
		end
	end

	assign short_d = (short_q & ~clr_short) | set_short;
	assign long_d = (long_q & ~clr_long) | set_long;

	assign status.pressed = (phase_q == PH_PRESSED);
	assign status.short_flag = short_q;
	assign status.long_flag = long_q;
	assign status.short_next = short_d;
	assign status.long_next = long_d;

endmodule

// ----- design/button_press_classifier.sv -----
// Qualifies BUTTONS active-low push buttons, one lane per button. A beat with
// tuser = tick carries the raw pin levels and advances every lane by one time
// unit: each lane debounces press and release, times the hold, and raises a
// short-press flag on a clean release from pressed or a long-press flag once
// the hold reaches long_press_ticks. Beats with tuser = short or long query
// read one flag by button number and clear it; a number past the last button
// reads zero. Every input beat yields exactly one output beat carrying the
// queried flag, the buzzer level with its start/stop strobes, and all pending
// flags. All lanes update side by side in the accepting cycle. Input flows at
// one beat per clock while the master side keeps up; results sit in an output
// register backed by a one-deep skid register, so one more beat is taken while
// a result waits. The user writes debounce_ticks (index 0) and long_press_ticks
// (index 1) through the cfg port only while idle; the block does not check it.
module button_press_classifier
	import bpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // button_levels[3:0], query_index[6:4], zero pad
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // query_flag, buzzer_on, buzzer_start,
	                               // buzzer_stop, pending_short[3:0],
	                               // pending_long[3:0], zero pad
);

	logic [AGE_W-1:0] debounce_q, long_press_q;

	logic in_acc, is_tick, is_short, is_long;
	logic [PIN_W-1:0] levels;
	logic [2:0] qi;
	logic [BUTTONS+PIN_W-1:0] levels_ext;

	bpc_lane_status_t status [BUTTONS];
	logic [BUTTONS-1:0] pressed_v, short_nv, long_nv;
	logic [BUTTONS+PIN_W-1:0] short_ext, long_ext;

	logic buzz_q, buzz_on, start_d, stop_d, flag_d;
	logic [RES_W-1:0] result_d;

	logic out_v_q, skid_v_q;
	logic [RES_W-1:0] out_q, skid_q;

	// config writes, always accepted; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEBOUNCE:   debounce_q <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input decode
	assign s_tready = !skid_v_q;
	assign in_acc = s_tvalid && s_tready;
	assign levels = s_tdata[3:0];
	assign qi = s_tdata[6:4];
	assign is_tick = in_acc && (s_tuser == REQ_TICK);
	assign is_short = in_acc && (s_tuser == REQ_SHORT);
	assign is_long = in_acc && (s_tuser == REQ_LONG);

	// lanes without a pin read as released (level high)
	assign levels_ext = {{BUTTONS{1'b1}}, levels};

	for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
		bpc_lane u_lane (
			.clk              (clk),
			.arst_n           (arst_n),
			.tick             (is_tick),
			.down             (~levels_ext[g]),
			.clr_short        (is_short && (qi == 3'(g))),
			.clr_long         (is_long && (qi == 3'(g))),
			.debounce_ticks   (debounce_q),
			.long_press_ticks (long_press_q),
			.status           (status[g])
		);
		assign pressed_v[g] = status[g].pressed;
		assign short_nv[g] = status[g].short_next;
		assign long_nv[g] = status[g].long_next;
	end

	// merge: query readout, buzzer, pending vectors
	always_comb begin
		flag_d = 1'b0;
		for (int i = 0; i < BUTTONS; i++) begin
			if (qi == 3'(i)) begin
				if (is_short)
					flag_d = flag_d | status[i].short_flag;
				if (is_long)
					flag_d = flag_d | status[i].long_flag;
			end
		end
	end

	// buzzer follows the phases seen at the start of the tick
	assign buzz_on = is_tick ? (|pressed_v) : buzz_q;
	assign start_d = is_tick && buzz_on && !buzz_q;
	assign stop_d = is_tick && !buzz_on && buzz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			buzz_q <= 1'b0;
		else if (is_tick)
			buzz_q <= buzz_on;
	end

	// only the first four lanes show in the pending fields
	assign short_ext = {{PIN_W{1'b0}}, short_nv};
	assign long_ext = {{PIN_W{1'b0}}, long_nv};

	assign result_d = {long_ext[PIN_W-1:0], short_ext[PIN_W-1:0],
	                   stop_d, start_d, buzz_on, flag_d};

	// output register plus skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || m_tready) begin
				out_v_q <= skid_v_q || in_acc;
				skid_v_q <= 1'b0;
			end else if (in_acc) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q)
				out_q <= skid_q;
			else if (in_acc)
				out_q <= result_d;
		end else if (in_acc) begin
			skid_q <= result_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {{(16 - RES_W){1'b0}}, out_q};

	// skid only fills behind a waiting result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a beat with no result ahead of it");

	// buzzer level moves only on an accepted tick
	a_buzz_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(buzz_q != $past(buzz_q)) |-> $past(is_tick))
		else $error("buzzer level changed without a tick");

	// a start strobe in a valid result must agree with the buzzer bits beside it
	a_strobe_level: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[2]) |-> (m_tdata[1] && !m_tdata[3]))
		else $error("buzzer start strobe without buzzer on");

endmodule
